// ===== design/tpms_pkg.sv =====
// ----------------------------------------------------------------------------
// tpms_pkg
// Shared types and constants for the tachometer speed regulator.
// ----------------------------------------------------------------------------
`default_nettype none
package tpms_pkg;

  localparam int CHANNELS = 2;

  localparam logic [31:0] EDGE_GUARD_US = 32'd2000;
  localparam logic [31:0] STALL_US      = 32'd1000000;
  localparam logic [32:0] SPEED_NUM     = 33'd7680000000;
  localparam logic [21:0] SPEED_MAX     = 22'h3FFFFF;
  localparam logic [31:0] RECIP_10      = 32'hCCCCCCCD;

  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_SET_RPM   = 3'd0;
  localparam logic [2:0] REG_KP        = 3'd1;
  localparam logic [2:0] REG_KI_DT     = 3'd2;
  localparam logic [2:0] REG_KD_PER_DT = 3'd3;
  localparam logic [2:0] REG_DUTY_CEIL = 3'd4;
  localparam logic [2:0] REG_ST_THR    = 3'd5;
  localparam logic [2:0] REG_ST_STEP   = 3'd6;
  localparam logic [2:0] REG_ST_LIMIT  = 3'd7;

  typedef struct packed {
    logic [13:0] set_rpm;
    logic [31:0] kp;
    logic [31:0] ki_dt;
    logic [31:0] kd_per_dt;
    logic [15:0] duty_ceil;
    logic [13:0] st_thr;
    logic [23:0] st_step;
    logic [15:0] st_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    set_rpm:   14'd0,
    kp:        32'd0,
    ki_dt:     32'd0,
    kd_per_dt: 32'd0,
    duty_ceil: 16'hFFFF,
    st_thr:    14'd0,
    st_step:   24'd0,
    st_limit:  16'd0
  };

endpackage
`default_nettype wire

// ===== design/tpms_div.sv =====
// ----------------------------------------------------------------------------
// tpms_div
// Restoring divider, one quotient bit per cycle: fixed speed numerator
// divided by the edge period.
// ----------------------------------------------------------------------------
`default_nettype none
module tpms_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [32:0]      quot
);

  logic [32:0] num_r, num_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [32:0] quot_r, quot_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[32]};
    if (start) begin
      num_nxt  = tpms_pkg::SPEED_NUM;
      rem_nxt  = '0;
      quot_nxt = '0;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[31:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt  = 32'(trial - {1'b0, divisor});
        quot_nxt = {quot_r[31:0], 1'b1};
      end else begin
        rem_nxt  = trial[31:0];
        quot_nxt = {quot_r[31:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

// ===== design/tpms_lane.sv =====
// ----------------------------------------------------------------------------
// tpms_lane
// One channel: edge timing, speed, smoothing, PID with startup control.
// ----------------------------------------------------------------------------
`default_nettype none
module tpms_lane (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tpms_pkg::cfg_t cfg,
  input  wire logic          accept,
  input  wire logic          edge_in,
  input  wire logic          tick,
  input  wire logic [31:0]   now_us,
  output logic               done,
  output logic [13:0]        rpm,
  output logic [15:0]        duty
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_SMUL = 4'd3;
  localparam logic [3:0] S_ERR  = 4'd4;
  localparam logic [3:0] S_MI   = 4'd5;
  localparam logic [3:0] S_INT  = 4'd6;
  localparam logic [3:0] S_MP   = 4'd7;
  localparam logic [3:0] S_MD   = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]  st_r;
  logic [31:0] now_r, last_r, per_r;
  logic [21:0] sn_r, ss_r;
  logic signed [33:0] int_r;
  logic signed [23:0] prev_r, e_r;
  logic [23:0] held_r;
  logic        start_r;
  logic        use_div_r;
  logic signed [57:0] mul_r, acc_r;
  logic        done_r;

  logic        div_start, div_done;
  logic [32:0] quot;
  logic [31:0] d_edge, d_stall;
  logic signed [32:0] ma;
  logic signed [24:0] mb;
  logic signed [57:0] prod;
  logic [25:0] smooth_sum;
  logic [57:0] smooth_prod;
  logic signed [49:0] int_sum;
  logic signed [49:0] lim;
  logic signed [41:0] out_v, slew, ceil_v;
  logic        st_nxt;

  tpms_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (per_r),
    .done    (div_done),
    .quot    (quot)
  );

  assign d_edge    = now_us - last_r;
  assign d_stall   = now_r - last_r;
  assign div_start = (st_r == S_CHK);

  always_comb begin
    ma = $signed({1'b0, cfg.kp});
    mb = 25'(e_r);
    case (st_r)
      S_MI:    ma = $signed({1'b0, cfg.ki_dt});
      S_MP:    begin
        ma = $signed({1'b0, cfg.kd_per_dt});
        mb = 25'(e_r) - 25'(prev_r);
      end
      default: ma = $signed({1'b0, cfg.kp});
    endcase
  end
  assign prod = ma * mb;

  assign smooth_sum  = 26'(ss_r) * 26'd9 + 26'(sn_r);
  assign smooth_prod = {32'd0, smooth_sum} * {26'd0, tpms_pkg::RECIP_10};

  assign lim     = $signed({18'd0, cfg.duty_ceil, 16'd0});
  assign int_sum = 50'(int_r) + 50'(mul_r >>> 8);

  always_comb begin
    st_nxt = start_r;
    if (start_r && ({2'b0, ss_r} >= {2'b0, cfg.st_thr, 8'd0})) st_nxt = 1'b0;
    out_v  = 42'(acc_r >>> 16);
    slew   = $signed({17'd0, 25'({1'b0, held_r} + {1'b0, cfg.st_step})});
    if (st_nxt && out_v > slew) out_v = slew;
    if (out_v < 0) out_v = '0;
    ceil_v = st_nxt ? $signed({18'd0, cfg.st_limit, 8'd0})
                    : $signed({18'd0, cfg.duty_ceil, 8'd0});
    if (out_v > ceil_v) out_v = ceil_v;
  end

  always_ff @(posedge clk) begin
    mul_r <= prod;
    if (!rst_n) begin
      st_r    <= S_IDLE;
      last_r  <= '0;
      per_r   <= '0;
      sn_r    <= '0;
      ss_r    <= '0;
      int_r   <= '0;
      prev_r  <= '0;
      held_r  <= '0;
      start_r <= 1'b1;
      done_r  <= 1'b0;
    end else begin
      done_r <= (st_r == S_OUT);
      unique case (st_r)
        S_IDLE: begin
          if (accept) begin
            if (edge_in && d_edge > tpms_pkg::EDGE_GUARD_US) begin
              per_r  <= d_edge;
              last_r <= now_us;
            end
            now_r <= now_us;
            if (tick) st_r <= S_CHK;
          end
        end
        S_CHK: begin
          use_div_r <= 1'b0;
          if (d_stall > tpms_pkg::STALL_US) begin
            per_r <= '0;
            sn_r  <= '0;
          end else begin
            use_div_r <= (per_r != '0);
          end
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (use_div_r) begin
              sn_r <= (quot > 33'(tpms_pkg::SPEED_MAX)) ? tpms_pkg::SPEED_MAX : quot[21:0];
            end
            st_r <= S_SMUL;
          end
        end
        S_SMUL: begin
          ss_r <= smooth_prod[56:35];
          st_r <= S_ERR;
        end
        S_ERR: begin
          e_r  <= $signed({2'b0, cfg.set_rpm, 8'd0}) - $signed({2'b0, ss_r});
          st_r <= S_MI;
        end
        S_MI:  st_r <= S_INT;
        S_INT: begin
          if (int_sum > lim) int_r <= 34'(lim);
          else if (int_sum < -lim) int_r <= 34'(-lim);
          else int_r <= 34'(int_sum);
          st_r <= S_MP;
        end
        S_MP: begin
          acc_r <= mul_r;
          st_r  <= S_MD;
        end
        S_MD: begin
          acc_r <= acc_r + mul_r + (58'(int_r) <<< 8);
          st_r  <= S_OUT;
        end
        S_OUT: begin
          start_r <= st_nxt;
          held_r  <= out_v[23:0];
          prev_r  <= e_r;
          st_r    <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign rpm  = sn_r[21:8];
  assign duty = held_r[23:8];

endmodule
`default_nettype wire

// ===== design/tach_pid_motor_speed_top.sv =====
// ----------------------------------------------------------------------------
// tach_pid_motor_speed_top
// Multi-channel tachometer speed regulator with PID duty control.
// ----------------------------------------------------------------------------
// A beat without a tick is taken without raising in_stall. A beat with a tick
// runs each lane's one-bit-per-cycle 33-bit period divider followed by the
// shared-multiplier PID sequence; all lanes run side by side and the result
// beat is loaded into the output register when every lane has finished and the
// output register is free. in_stall is high while a tick is in work or its
// result waits for a free output register.
`default_nettype none
module tach_pid_motor_speed_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_now_us,
  input  wire logic        in_edge_a,
  input  wire logic        in_edge_b,
  input  wire logic        in_sample_tick,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [13:0]      out_rpm_a,
  output logic [13:0]      out_rpm_b,
  output logic [15:0]      out_duty_a,
  output logic [15:0]      out_duty_b,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [tpms_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int N = tpms_pkg::CHANNELS;

  tpms_pkg::cfg_t cfg_r;
  logic           busy_r, pend_r, out_valid_r;
  logic [13:0]    rpm_a_r, rpm_b_r;
  logic [15:0]    duty_a_r, duty_b_r;
  logic           accept, have, slot_free;
  logic [N-1:0]   lane_done;
  logic [13:0]    lane_rpm  [N];
  logic [15:0]    lane_duty [N];
  logic [2:0]     reg_idx;

  assign accept  = in_valid && !in_stall;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      tpms_pkg::REG_SET_RPM:   prdata = {18'd0, cfg_r.set_rpm};
      tpms_pkg::REG_KP:        prdata = cfg_r.kp;
      tpms_pkg::REG_KI_DT:     prdata = cfg_r.ki_dt;
      tpms_pkg::REG_KD_PER_DT: prdata = cfg_r.kd_per_dt;
      tpms_pkg::REG_DUTY_CEIL: prdata = {16'd0, cfg_r.duty_ceil};
      tpms_pkg::REG_ST_THR:    prdata = {18'd0, cfg_r.st_thr};
      tpms_pkg::REG_ST_STEP:   prdata = {8'd0, cfg_r.st_step};
      default:                 prdata = {16'd0, cfg_r.st_limit};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tpms_pkg::CFG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        tpms_pkg::REG_SET_RPM:   cfg_r.set_rpm   <= pwdata[13:0];
        tpms_pkg::REG_KP:        cfg_r.kp        <= pwdata;
        tpms_pkg::REG_KI_DT:     cfg_r.ki_dt     <= pwdata;
        tpms_pkg::REG_KD_PER_DT: cfg_r.kd_per_dt <= pwdata;
        tpms_pkg::REG_DUTY_CEIL: cfg_r.duty_ceil <= pwdata[15:0];
        tpms_pkg::REG_ST_THR:    cfg_r.st_thr    <= pwdata[13:0];
        tpms_pkg::REG_ST_STEP:   cfg_r.st_step   <= pwdata[23:0];
        default:                 cfg_r.st_limit  <= pwdata[15:0];
      endcase
    end
  end

  for (genvar c = 0; c < N; c++) begin : g_lane
    logic edge_c;
    if (c == 0) begin : g_a
      assign edge_c = in_edge_a;
    end else if (c == 1) begin : g_b
      assign edge_c = in_edge_b;
    end else begin : g_none
      assign edge_c = 1'b0;
    end
    tpms_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg     (cfg_r),
      .accept  (accept),
      .edge_in (edge_c),
      .tick    (in_sample_tick),
      .now_us  (in_now_us),
      .done    (lane_done[c]),
      .rpm     (lane_rpm[c]),
      .duty    (lane_duty[c])
    );
  end

  assign have      = pend_r || (&lane_done);
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (have && slot_free) begin
      rpm_a_r  <= lane_rpm[0];
      duty_a_r <= lane_duty[0];
      if (N > 1) begin
        rpm_b_r  <= lane_rpm[N > 1 ? 1 : 0];
        duty_b_r <= lane_duty[N > 1 ? 1 : 0];
      end else begin
        rpm_b_r  <= '0;
        duty_b_r <= '0;
      end
    end
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (have && slot_free) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
        busy_r      <= 1'b0;
      end else begin
        if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
        if (&lane_done) pend_r <= 1'b1;
      end
      if (accept && in_sample_tick) busy_r <= 1'b1;
    end
  end

  assign in_stall   = busy_r;
  assign out_valid  = out_valid_r;
  assign out_rpm_a  = rpm_a_r;
  assign out_rpm_b  = rpm_b_r;
  assign out_duty_a = duty_a_r;
  assign out_duty_b = duty_b_r;

endmodule
`default_nettype wire
